// File: hdl/ptsch_pkg.sv
// shared types, field widths and command codes of the periodic task scheduler
// depends on nothing
package ptsch_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W  = 2;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 8;
    localparam int PER_W  = 16;
    localparam int IDX_W  = 4;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_time;
        logic [TAG_W-1:0]  task_tag;
        logic [PER_W-1:0]  period;
        logic [PER_W-1:0]  start_delay;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              fired;
        logic [TAG_W-1:0]  fired_tag;
        logic [IDX_W-1:0]  slot_index;
        logic              last;
    } t_out_item;

    // one slot of the task table
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] due;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [PER_W-1:0]  divisor;
    } t_rem_req;

    typedef struct packed {
        logic              done;
        logic [PER_W-1:0]  remainder;
    } t_rem_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_READ,
        S_DIV,
        S_HANDOFF,
        S_FINISH
    } t_state;

endpackage

// File: hdl/ptsch_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
// depends on nothing; the payload type is set per instance
interface ptsch_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ptsch_ram.sv
// generic single write port ram with registered read
// depends on nothing
module ptsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/ptsch_rem.sv
// iterative restoring remainder unit, one dividend bit per cycle
// depends on ptsch_pkg
module ptsch_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptsch_pkg::t_rem_req i_req,
    output ptsch_pkg::t_rem_rsp o_rsp
);
    import ptsch_pkg::*;

    localparam int STEP_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_quo;
    logic [PER_W-1:0]  r_div;
    logic [PER_W-1:0]  r_rem;
    logic [PER_W-1:0]  n_rem;
    logic [PER_W:0]    trial;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_quo[TIME_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = PER_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[PER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == STEP_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= r_quo << 1;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("remainder unit restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a running division");
    a_nonzero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_div != '0) else $error("division by a zero period");
endmodule

// File: hdl/periodic_task_scheduler_core.sv
// periodic task scheduler: sequencer, slot table ram and shared remainder unit
// clear empties the table; register walks to the lowest free slot; run skips free slots,
// reads used ones and runs the 32-step remainder for each due slot
// one transfer in at a time; the next is taken once the last result is registered
// reset (synchronous, active low) empties the table at once through the used bits
// depends on ptsch_pkg, ptsch_stream_if, ptsch_ram, ptsch_rem
module periodic_task_scheduler_core #(
    parameter int TASK_SLOTS = ptsch_pkg::TASK_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptsch_stream_if.sink    i_in,
    ptsch_stream_if.source  o_res
);
    import ptsch_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    // control state
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TASK_SLOTS-1:0] r_used, n_used;
    logic                r_pend_valid, n_pend_valid;
    logic                r_out_valid;

    // payload
    t_in_item            r_item, n_item;
    t_out_item           r_pend, n_pend;
    t_out_item           r_out;

    // datapath
    logic                out_free;
    logic                push;
    t_out_item           push_item;
    logic                ram_we, ram_re;
    t_entry              ram_wdata, ram_rdata;
    t_rem_req            rem_req;
    t_rem_rsp            rem_rsp;
    logic [TIME_W-1:0]   since_due;
    logic [TIME_W-1:0]   next_due;
    logic                last_slot;

    ptsch_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    ptsch_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    // wrap-safe distance from the due time; bit 31 clear means due
    assign since_due = r_item.now_time - ram_rdata.due;
    // due + (floor(d/p)+1)*p reduces to now - (d mod p) + p
    assign next_due  = r_item.now_time - TIME_W'(rem_rsp.remainder)
                     + TIME_W'(ram_rdata.period);
    assign last_slot = (r_slot == SLOT_W'(TASK_SLOTS - 1));
    assign out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_count      = r_count;
        n_used       = r_used;
        n_pend_valid = r_pend_valid;
        n_item       = r_item;
        n_pend       = r_pend;
        push         = 1'b0;
        push_item    = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = '0;
        rem_req.start    = 1'b0;
        rem_req.dividend = since_due;
        rem_req.divisor  = ram_rdata.period;
        i_in.ready   = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_item       = i_in.data;
                    n_slot       = '0;
                    n_count      = '0;
                    n_pend_valid = 1'b0;
                    case (i_in.data.cmd)
                        CMD_REGISTER: begin
                            if (i_in.data.task_tag != '0 && i_in.data.period != '0) begin
                                n_state = S_FIND;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        CMD_RUN: begin
                            n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_used  = '0;
                            n_state = S_FINISH;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            // walk to the lowest free slot
            S_FIND: begin
                if (!r_used[r_slot]) begin
                    ram_we            = 1'b1;
                    ram_wdata.tag     = r_item.task_tag;
                    ram_wdata.period  = r_item.period;
                    ram_wdata.due     = r_item.now_time + TIME_W'(r_item.start_delay);
                    n_used[r_slot]    = 1'b1;
                    n_pend_valid      = 1'b1;
                    n_pend            = '0;
                    n_pend.accepted   = 1'b1;
                    n_pend.slot_index = IDX_W'(r_slot);
                    n_state           = S_FINISH;
                end else if (last_slot) begin
                    n_state = S_FINISH;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end

            // skip free slots, fetch used ones
            S_SCAN: begin
                if (r_used[r_slot]) begin
                    ram_re  = 1'b1;
                    n_state = S_READ;
                end else if (last_slot) begin
                    n_state = S_FINISH;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end

            S_READ: begin
                if (!since_due[TIME_W-1]) begin
                    rem_req.start = 1'b1;
                    n_state       = S_DIV;
                end else if (last_slot) begin
                    n_state = S_FINISH;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_SCAN;
                end
            end

            // wait for the remainder, then write back the advanced due time
            S_DIV: begin
                if (rem_rsp.done) begin
                    ram_we           = 1'b1;
                    ram_wdata.tag    = ram_rdata.tag;
                    ram_wdata.period = ram_rdata.period;
                    ram_wdata.due    = next_due;
                    n_count          = r_count + 1'b1;
                    n_state          = S_HANDOFF;
                end
            end

            // one result held back so the final one can carry last
            S_HANDOFF: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        push      = 1'b1;
                        push_item = r_pend;
                    end
                    n_pend_valid      = 1'b1;
                    n_pend            = '0;
                    n_pend.fired      = 1'b1;
                    n_pend.fired_tag  = ram_rdata.tag;
                    n_pend.slot_index = IDX_W'(r_slot);
                    if (r_count == CNT_W'(MAX_RESULTS) || last_slot) begin
                        n_state = S_FINISH;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_pend_valid) begin
                        push_item = r_pend;
                    end
                    push_item.last = 1'b1;
                    n_pend_valid   = 1'b0;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_count      <= '0;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_count      <= n_count;
            r_used       <= n_used;
            r_pend_valid <= n_pend_valid;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pend <= n_pend;
        if (push) begin
            r_out <= push_item;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("new item taken while the previous one is in work");
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RESULTS)) else $error("result count past its limit");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_rsp.done |-> r_state == S_DIV) else $error("remainder done out of sequence");
    a_writeback_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_DIV) |-> r_used[r_slot])
        else $error("due time written back to a free slot");
endmodule

// File: verif/tb_periodic_task_scheduler_core.sv
// self-checking testbench of periodic_task_scheduler_core: directed and random commands
// with a task table predictor; depends on ptsch_pkg, ptsch_stream_if and the rtl
module tb_periodic_task_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ptsch_pkg::*;

    localparam int N_SLOTS      = TASK_SLOTS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int GAP_MAX      = 30;
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ptsch_stream_if #(.T(t_in_item))  cmd_ch ();
    ptsch_stream_if #(.T(t_out_item)) res_ch ();

    periodic_task_scheduler_core #(.TASK_SLOTS(N_SLOTS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_res   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // predicted task table
    bit                sl_used [N_SLOTS];
    logic [TAG_W-1:0]  sl_tag  [N_SLOTS];
    logic [PER_W-1:0]  sl_per  [N_SLOTS];
    logic [TIME_W-1:0] sl_due  [N_SLOTS];

    // scheduler replies still owed by the block, oldest first
    t_out_item replies_q [$];

    int err_cnt      = 0;
    int n_reg_taken  = 0;
    int n_reg_reject = 0;
    int n_runs       = 0;
    int n_fired      = 0;
    int n_clears     = 0;
    int n_unused     = 0;
    int max_burst    = 0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_go        = 1'b0;
    int hold_cnt       = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    int unsigned cycle_cnt = 0;

    // table update and replies for one accepted command
    function automatic void apply_cmd(input t_in_item it);
        t_out_item   r;
        t_out_item   burst [$];
        logic [31:0] lag;
        logic [63:0] periods;
        r      = '0;
        r.last = 1'b1;
        case (it.cmd)
            CMD_REGISTER: begin
                if (it.task_tag != '0 && it.period != '0) begin
                    // lowest free slot wins
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (!sl_used[i]) begin
                            sl_used[i]   = 1'b1;
                            sl_tag[i]    = it.task_tag;
                            sl_per[i]    = it.period;
                            sl_due[i]    = it.now_time + TIME_W'(it.start_delay);
                            r.accepted   = 1'b1;
                            r.slot_index = IDX_W'(i);
                            break;
                        end
                    end
                end
                if (r.accepted) n_reg_taken++;
                else n_reg_reject++;
                replies_q.push_back(r);
            end
            CMD_RUN: begin
                n_runs++;
                for (int i = 0; i < N_SLOTS && burst.size() < MAX_RESULTS; i++) begin
                    // due when now minus due is not negative as a signed 32-bit value
                    lag = it.now_time - sl_due[i];
                    if (sl_used[i] && !lag[31]) begin
                        r            = '0;
                        r.fired      = 1'b1;
                        r.fired_tag  = sl_tag[i];
                        r.slot_index = IDX_W'(i);
                        burst.push_back(r);
                        // skip missed runs: smallest whole number of periods past now
                        periods   = 64'(lag) / 64'(sl_per[i]) + 64'd1;
                        sl_due[i] = 32'(64'(sl_due[i]) + periods * 64'(sl_per[i]));
                    end
                end
                if (burst.size() == 0) begin
                    r      = '0;
                    r.last = 1'b1;
                    replies_q.push_back(r);
                end else begin
                    n_fired += burst.size();
                    if (burst.size() > max_burst) max_burst = burst.size();
                    foreach (burst[k]) begin
                        r      = burst[k];
                        r.last = (k == burst.size() - 1);
                        replies_q.push_back(r);
                    end
                end
            end
            CMD_CLEAR: begin
                n_clears++;
                for (int i = 0; i < N_SLOTS; i++) begin
                    sl_used[i] = 1'b0;
                    sl_tag[i]  = '0;
                    sl_per[i]  = '0;
                    sl_due[i]  = '0;
                end
                replies_q.push_back(r);
            end
            default: begin
                n_unused++;
                replies_q.push_back(r);
            end
        endcase
    endfunction

    function automatic t_in_item cmd_item(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                                          input logic [TAG_W-1:0] tg, input logic [PER_W-1:0] pr,
                                          input logic [PER_W-1:0] dl);
        t_in_item it;
        it.cmd         = c;
        it.now_time    = t;
        it.task_tag    = tg;
        it.period      = pr;
        it.start_delay = dl;
        return it;
    endfunction

    // one command transfer; valid stays high afterwards so back-to-back items need no gap
    task automatic send_cmd(input t_in_item it);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
        apply_cmd(it);
    endtask

    // stop offering and wait for every owed reply, then a little longer for strays
    task automatic wait_quiet();
        cmd_ch.valid <= 1'b0;
        while (replies_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver: random stalls, or a long hold-off counted below
    always @(posedge i_clk) begin
        res_ch.ready <= (hold_cnt == 0 && !hold_go) && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d replies outstanding", $realtime, replies_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, what, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (replies_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none actual %0h", $realtime,
                         res_ch.data);
            end else begin
                want = replies_q.pop_front();
                cmp_field("accepted",   32'(want.accepted),   32'(res_ch.data.accepted));
                cmp_field("fired",      32'(want.fired),      32'(res_ch.data.fired));
                cmp_field("fired_tag",  32'(want.fired_tag),  32'(res_ch.data.fired_tag));
                cmp_field("slot_index", 32'(want.slot_index), 32'(res_ch.data.slot_index));
                cmp_field("last",       32'(want.last),       32'(res_ch.data.last));
            end
        end
    end

    // empty table, ignored command code and malformed registrations
    task automatic test_empty_and_rejects();
        send_cmd(cmd_item(CMD_RUN, 32'h0, 8'h00, 16'h0000, 16'h0000));
        send_cmd(cmd_item(CMD_UNUSED, '1, '1, '1, '1));
        send_cmd(cmd_item(CMD_REGISTER, 32'h0000_1000, 8'h00, 16'd5, 16'd0));
        send_cmd(cmd_item(CMD_REGISTER, 32'h0000_1000, 8'h07, 16'h0000, 16'd3));
        wait_quiet();
    endtask

    // fill every slot across the time wrap, overflow, then one run firing all sixteen
    task automatic test_full_table();
        logic [TAG_W-1:0] tg;
        logic [PER_W-1:0] pr;
        logic [PER_W-1:0] dl;
        for (int i = 0; i < N_SLOTS; i++) begin
            tg = (i == 0) ? 8'hFF : TAG_W'(i * 13 + 1);
            pr = (i == 0) ? 16'hFFFF : PER_W'(i + 1);
            dl = (i == 0) ? 16'hFFFF : PER_W'((i - 1) * 16);
            send_cmd(cmd_item(CMD_REGISTER, 32'hFFFF_FF00, tg, pr, dl));
        end
        // table full, a valid registration is turned away
        send_cmd(cmd_item(CMD_REGISTER, 32'hFFFF_FF00, 8'h42, 16'd10, 16'd0));
        send_cmd(cmd_item(CMD_RUN, 32'h0001_0000, 8'h00, 16'h0000, 16'h0000));
        // due times moved strictly past now, so a repeat at the same time finds nothing
        send_cmd(cmd_item(CMD_RUN, 32'h0001_0000, 8'h00, 16'h0000, 16'h0000));
        send_cmd(cmd_item(CMD_CLEAR, 32'h0, 8'h00, 16'h0000, 16'h0000));
        wait_quiet();
    endtask

    // signed compare edge: half the range ahead reads as behind
    task automatic test_wrap_compare();
        send_cmd(cmd_item(CMD_REGISTER, 32'h0, 8'h5A, 16'd100, 16'd0));
        send_cmd(cmd_item(CMD_REGISTER, 32'h0, 8'hA5, 16'd1, 16'd0));
        send_cmd(cmd_item(CMD_RUN, 32'h8000_0000, 8'h00, 16'h0000, 16'h0000));
        send_cmd(cmd_item(CMD_RUN, 32'h7FFF_FFFF, 8'h00, 16'h0000, 16'h0000));
        wait_quiet();
    endtask

    // one random phase; mostly registrations and runs on an advancing clock
    task automatic random_phase(input int src_pct, input int sink_pct, input int n_items);
        int               done;
        int               sel;
        int               p;
        logic [TAG_W-1:0] tg;
        logic [PER_W-1:0] pr;
        logic [PER_W-1:0] dl;
        logic [31:0]      adv;
        t_in_item         it;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        done = 0;
        while (done < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 32) begin
                tg = TAG_W'($urandom_range(1, 255));
                p  = $urandom_range(0, 9);
                pr = (p < 7) ? PER_W'($urandom_range(1, 64)) :
                     (p < 9) ? PER_W'($urandom_range(65, 4000)) :
                               PER_W'($urandom_range(1, 65535));
                dl = ($urandom_range(0, 4) < 3) ? PER_W'($urandom_range(0, 100)) :
                                                  PER_W'($urandom);
                it = cmd_item(CMD_REGISTER, clock_ms, tg, pr, dl);
            end else if (sel < 78) begin
                // mostly small steps so tasks keep firing, now and then a long jump
                p   = $urandom_range(0, 49);
                adv = (p < 35) ? $urandom_range(0, 40) :
                      (p < 45) ? $urandom_range(41, 5000) :
                      (p < 49) ? $urandom_range(0, 1 << 20) : $urandom;
                clock_ms = clock_ms + adv;
                it = cmd_item(CMD_RUN, clock_ms, TAG_W'($urandom), PER_W'($urandom),
                              PER_W'($urandom));
            end else if (sel < 82) begin
                it = cmd_item(CMD_CLEAR, $urandom, TAG_W'($urandom), PER_W'($urandom),
                              PER_W'($urandom));
            end else if (sel < 90) begin
                // malformed registration: zero tag or zero period
                tg = $urandom_range(0, 1) ? '0 : TAG_W'($urandom);
                pr = (tg == '0) ? PER_W'($urandom) : '0;
                it = cmd_item(CMD_REGISTER, $urandom, tg, pr, PER_W'($urandom));
            end else if (sel < 95) begin
                it = cmd_item(CMD_RUN, $urandom, TAG_W'($urandom), PER_W'($urandom),
                              PER_W'($urandom));
            end else begin
                it = cmd_item(CMD_UNUSED, $urandom, TAG_W'($urandom), PER_W'($urandom),
                              PER_W'($urandom));
            end
            send_cmd(it);
            if (it.cmd != CMD_UNUSED) done++;
        end
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        clock_ms = $urandom;
        random_phase(0, 0, 50);
        random_phase(64, 0, 50);
        random_phase(0, 64, 50);
        random_phase(7, 7, 52);
    endtask

    // receiver holds off while commands keep coming, so the block backs up its input
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        for (int i = 0; i < 4; i++) begin
            send_cmd(cmd_item(CMD_REGISTER, clock_ms, TAG_W'($urandom_range(1, 255)),
                              PER_W'($urandom_range(1, 8)), 16'd0));
            clock_ms = clock_ms + 32'd9;
            send_cmd(cmd_item(CMD_RUN, clock_ms, 8'h00, 16'h0000, 16'h0000));
        end
        wait_quiet();
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_rejects();
        test_full_table();
        test_wrap_compare();
        test_backpressure();
        test_random_traffic();
        wait_quiet();

        $display("covered %0d registrations taken, %0d turned away, %0d runs, %0d clears",
                 n_reg_taken, n_reg_reject, n_runs, n_clears);
        $display("%0d ignored, tasks fired %0d times, longest burst %0d, %0d mismatches",
                 n_unused, n_fired, max_burst, err_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
